FILE: rtl/mie_pkg.sv
`timescale 1ns / 1ps

package mie_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int MODULUS_RESET  = 13;
    localparam int MAX_ROUNDS     = 128;
    localparam int ROUND_BITS     = $clog2(MAX_ROUNDS);

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

FILE: rtl/mie_ifs.sv
`timescale 1ns / 1ps

interface mie_op_if #(
    parameter int VALUE_BITS = mie_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] operand_value;

    modport source (output valid, output operand_value, input ready);
    modport sink   (input valid, input operand_value, output ready);
endinterface

interface mie_res_if #(
    parameter int VALUE_BITS = mie_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] inverse_value;

    modport source (output valid, output inverse_value, input ready);
    modport sink   (input valid, input inverse_value, output ready);
endinterface

interface mie_cfg_if #(
    parameter int VALUE_BITS = mie_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

FILE: rtl/mie_step_unit.sv
`timescale 1ns / 1ps

module mie_step_unit #(
    parameter int VALUE_BITS = mie_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0] i_div_rem,
    input  logic                  i_div_bit,
    input  logic [VALUE_BITS-1:0] i_divisor,
    input  logic [VALUE_BITS-1:0] i_acc,
    input  logic                  i_qbit,
    input  logic [VALUE_BITS-1:0] i_coef_cur,
    input  logic [VALUE_BITS-1:0] i_coef_old,
    input  logic [VALUE_BITS-1:0] i_modulus,
    output logic [VALUE_BITS-1:0] o_div_rem,
    output logic                  o_qbit,
    output logic [VALUE_BITS-1:0] o_acc,
    output logic [VALUE_BITS-1:0] o_coef_new
);

    logic [VALUE_BITS:0]   div_x;
    logic [VALUE_BITS:0]   div_diff;
    logic [VALUE_BITS+1:0] mul_t;
    logic [VALUE_BITS+1:0] mod_1;
    logic [VALUE_BITS+1:0] mod_2;
    logic [VALUE_BITS:0]   coef_diff;

    // One restoring division step.
    always_comb begin
        div_x    = {i_div_rem, i_div_bit};
        div_diff = div_x - {1'b0, i_divisor};
        o_qbit   = (div_x >= {1'b0, i_divisor});
        o_div_rem = o_qbit ? div_diff[VALUE_BITS-1:0] : div_x[VALUE_BITS-1:0];
    end

    // One Horner step of the modular product, most significant quotient bit first.
    always_comb begin
        mod_1 = {2'b00, i_modulus};
        mod_2 = {1'b0, i_modulus, 1'b0};
        mul_t = {1'b0, i_acc, 1'b0} + (i_qbit ? {2'b00, i_coef_cur} : '0);
        if (mul_t >= mod_2) begin
            o_acc = VALUE_BITS'(mul_t - mod_2);
        end else if (mul_t >= mod_1) begin
            o_acc = VALUE_BITS'(mul_t - mod_1);
        end else begin
            o_acc = mul_t[VALUE_BITS-1:0];
        end
    end

    // Next coefficient, lifted into the range below the modulus.
    always_comb begin
        coef_diff  = {1'b0, i_coef_old} - {1'b0, i_acc};
        o_coef_new = coef_diff[VALUE_BITS] ? (coef_diff[VALUE_BITS-1:0] + i_modulus)
                                           : coef_diff[VALUE_BITS-1:0];
    end

endmodule

FILE: rtl/mie_core.sv
`timescale 1ns / 1ps

module mie_core #(
    parameter int VALUE_BITS = mie_pkg::VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_BITS-1:0]  i_operand,
    input  logic [VALUE_BITS-1:0]  i_modulus,
    input  logic                   i_done_ack,
    output mie_pkg::t_core_stat    o_stat,
    output logic [VALUE_BITS-1:0]  o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS);
    localparam logic [mie_pkg::ROUND_BITS-1:0] ROUND_LAST =
        mie_pkg::ROUND_BITS'(mie_pkg::MAX_ROUNDS - 1);

    logic [1:0]                        r_state, n_state;
    logic [CNT_BITS-1:0]               r_cnt, n_cnt;
    logic [mie_pkg::ROUND_BITS-1:0]    r_round, n_round;
    logic [VALUE_BITS-1:0]             r_rcur, n_rcur;
    logic [VALUE_BITS-1:0]             r_cold, n_cold;
    logic [VALUE_BITS-1:0]             r_ccur, n_ccur;
    logic [VALUE_BITS-1:0]             r_rem, n_rem;
    logic [VALUE_BITS-1:0]             r_num, n_num;
    logic                              r_qbit, n_qbit;
    logic [VALUE_BITS-1:0]             r_acc, n_acc;
    logic [VALUE_BITS-1:0]             r_mod, n_mod;

    logic [VALUE_BITS-1:0] step_rem;
    logic                  step_qbit;
    logic [VALUE_BITS-1:0] step_acc;
    logic [VALUE_BITS-1:0] step_coef;

    mie_step_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_div_rem  (r_rem),
        .i_div_bit  (r_num[VALUE_BITS-1]),
        .i_divisor  (r_rcur),
        .i_acc      (r_acc),
        .i_qbit     (r_qbit),
        .i_coef_cur (r_ccur),
        .i_coef_old (r_cold),
        .i_modulus  (r_mod),
        .o_div_rem  (step_rem),
        .o_qbit     (step_qbit),
        .o_acc      (step_acc),
        .o_coef_new (step_coef)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_round = r_round;
        n_rcur  = r_rcur;
        n_cold  = r_cold;
        n_ccur  = r_ccur;
        n_rem   = r_rem;
        n_num   = r_num;
        n_qbit  = r_qbit;
        n_acc   = r_acc;
        n_mod   = r_mod;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_mod   = i_modulus;
                    n_rcur  = i_operand;
                    n_cold  = '0;
                    n_ccur  = VALUE_BITS'(1);
                    n_round = '0;
                    n_rem   = '0;
                    n_num   = i_modulus;
                    n_acc   = '0;
                    n_qbit  = 1'b0;
                    n_cnt   = '0;
                    if ((i_modulus < VALUE_BITS'(2)) || (i_operand == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt != CNT_LAST) begin
                    n_rem  = step_rem;
                    n_qbit = step_qbit;
                    n_num  = {r_num[VALUE_BITS-2:0], 1'b0};
                end
                if (r_cnt != '0) begin
                    n_acc = step_acc;
                end
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_rcur  = r_rem;
                n_cold  = r_ccur;
                n_ccur  = step_coef;
                n_round = r_round + mie_pkg::ROUND_BITS'(1);
                n_num   = r_rcur;
                n_rem   = '0;
                n_acc   = '0;
                n_qbit  = 1'b0;
                n_cnt   = '0;
                if ((r_rem == '0) || (r_round == ROUND_LAST)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DONE: begin
                if (i_done_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt   <= n_cnt;
        r_round <= n_round;
        r_rcur  <= n_rcur;
        r_cold  <= n_cold;
        r_ccur  <= n_ccur;
        r_rem   <= n_rem;
        r_num   <= n_num;
        r_qbit  <= n_qbit;
        r_acc   <= n_acc;
        r_mod   <= n_mod;
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_result    = r_cold;

endmodule

FILE: rtl/modular_inverse_ext_euclid_unit.sv
`timescale 1ns / 1ps

// Port       Dir  Payload         Transaction
// i_op       in   operand_value   value to invert, taken when valid and ready are high
// o_res      out  inverse_value   inverse modulo the modulus, one per input transaction
// i_cfg      in   modulus         new modulus, always ready, write only while idle
//
// Each Euclid round computes one restoring division bit per cycle, with the modular
// product of quotient and coefficient formed in the cycle after each bit in
// the same shared step unit, and then ends in one update state.
// Reset is synchronous and active low and sets the modulus to 13.
// A finished result waits in the output register, and a new input transaction is
// taken while it waits; the sequencer stalls only when a second result is ready.

module modular_inverse_ext_euclid_unit #(
    parameter int VALUE_BITS = mie_pkg::VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mie_op_if.sink    i_op,
    mie_res_if.source o_res,
    mie_cfg_if.sink   i_cfg
);

    logic [VALUE_BITS-1:0] r_modulus;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_data;

    mie_pkg::t_core_stat   core_stat;
    logic [VALUE_BITS-1:0] core_result;
    logic                  out_free;
    logic                  done_ack;
    logic                  start;

    assign out_free    = !r_out_valid || o_res.ready;
    assign done_ack    = core_stat.done && out_free;
    assign start       = i_op.valid && core_stat.idle;
    assign i_op.ready  = core_stat.idle;
    assign i_cfg.ready = 1'b1;

    mie_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_operand  (i_op.operand_value),
        .i_modulus  (r_modulus),
        .i_done_ack (done_ack),
        .o_stat     (core_stat),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= VALUE_BITS'(mie_pkg::MODULUS_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_modulus <= i_cfg.modulus;
            end
            if (done_ack) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (done_ack) begin
            r_out_data <= core_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.inverse_value = r_out_data;

endmodule
